// File: hdl/rsb_pkg.sv
`default_nettype none

package rsb_pkg;

    localparam int SLOTS_DEF = 8;

    localparam int FUNC_W       = 2;
    localparam int SLOT_FIELD_W = 3;
    localparam int TIME_W       = 32;
    localparam int FLOOR_W      = 8;
    localparam int OCC_FIELD_W  = 4;

    // stream widths; the tdata widths are padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 56;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_TAKE   = 2'd2,
        FUNC_NEWEST = 2'd3
    } func_t;

    // controller to datapath
    typedef struct packed {
        logic load_op;
        logic exec_simple;
        logic take_issue;
        logic take_done;
        logic scan_start;
        logic scan_step;
        logic scan_done;
    } rsb_cmd_t;

    // datapath to controller
    typedef struct packed {
        func_t func;
        logic  out_free;
        logic  scan_last;
    } rsb_status_t;

endpackage

`default_nettype wire

// File: hdl/rsb_controller.sv
`default_nettype none

module rsb_controller (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  rsb_pkg::rsb_status_t status,
    output rsb_pkg::rsb_cmd_t    cmd
);
    import rsb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_EXEC      = 6'b000010,
        ST_TAKE_RD   = 6'b000100,
        ST_SCAN      = 6'b001000,
        ST_SCAN_TAIL = 6'b010000,
        ST_SCAN_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_op = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.func)
                    FUNC_ADD, FUNC_REMOVE: begin
                        if (status.out_free) begin
                            cmd.exec_simple = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    FUNC_TAKE: begin
                        cmd.take_issue = 1'b1;
                        state_next     = ST_TAKE_RD;
                    end
                    FUNC_NEWEST: begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_TAKE_RD: begin
                if (status.out_free) begin
                    cmd.take_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_SCAN_TAIL;
                end
            end
            // last compare lands here
            ST_SCAN_TAIL: begin
                state_next = ST_SCAN_OUT;
            end
            ST_SCAN_OUT: begin
                if (status.out_free) begin
                    cmd.scan_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/rsb_datapath.sv
`default_nettype none

module rsb_datapath #(
    parameter int SLOTS = rsb_pkg::SLOTS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire  [rsb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire  [rsb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [rsb_pkg::M_TDATA_W-1:0] m_tdata,
    input  rsb_pkg::rsb_cmd_t             cmd,
    output rsb_pkg::rsb_status_t          status
);
    import rsb_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int PAD_W = M_TDATA_W - (1 + SLOT_FIELD_W + TIME_W + FLOOR_W + OCC_FIELD_W + 2);

    // captured request
    func_t                    func_reg;
    logic [SLOT_FIELD_W-1:0]  index_reg;
    logic [TIME_W-1:0]        time_reg;
    logic [FLOOR_W-1:0]       floor_reg;

    // slot state
    logic [SLOTS-1:0]         valid_reg;
    logic [CNT_W-1:0]         occ_reg;
    logic [IDX_W-1:0]         ptr_reg;

    // slot payload memory
    logic [TIME_W-1:0]        mem_time  [SLOTS];
    logic [FLOOR_W-1:0]       mem_floor [SLOTS];
    logic [TIME_W-1:0]        rd_time_reg;
    logic [FLOOR_W-1:0]       rd_floor_reg;
    logic                     mem_we;
    logic                     mem_re;
    logic [IDX_W-1:0]         rd_addr;

    // take-next bookkeeping
    logic                     take_ok_reg;
    logic [IDX_W-1:0]         take_idx_reg;

    // newest scan
    logic [IDX_W-1:0]         scan_idx_reg;
    logic                     scan_cmp_reg;
    logic                     scan_vld_reg;
    logic [IDX_W-1:0]         scan_slot_reg;
    logic                     best_ok_reg;
    logic [IDX_W-1:0]         best_slot_reg;
    logic [TIME_W-1:0]        best_time_reg;
    logic [FLOOR_W-1:0]       best_floor_reg;

    // output register
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    // combinational search results
    logic                     free_found;
    logic [IDX_W-1:0]         free_idx;
    logic                     take_found;
    logic [IDX_W-1:0]         take_idx;
    logic [IDX_W-1:0]         ptr_after;
    logic                     rem_ok;
    logic [IDX_W-1:0]         rem_idx;

    logic                     res_load;
    logic                     res_ok;
    logic [IDX_W-1:0]         res_slot;
    logic [TIME_W-1:0]        res_time;
    logic [FLOOR_W-1:0]       res_floor;
    logic [CNT_W-1:0]         res_occ;
    logic [SLOT_FIELD_W-1:0]  out_slot;
    logic [TIME_W-1:0]        out_time;
    logic [FLOOR_W-1:0]       out_floor;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // first occupied slot at or after the pointer, wrapping
    always_comb begin
        int                 sum;
        logic [IDX_W-1:0]   k;
        take_found = 1'b0;
        take_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            sum = int'(ptr_reg) + i;
            if (sum >= SLOTS) begin
                sum = sum - SLOTS;
            end
            k = IDX_W'(sum);
            if (valid_reg[k]) begin
                take_found = 1'b1;
                take_idx   = k;
            end
        end
    end

    assign ptr_after = (take_idx == IDX_W'(SLOTS - 1)) ? '0 : take_idx + 1'b1;

    assign rem_idx = IDX_W'(index_reg);
    assign rem_ok  = (int'(index_reg) < SLOTS) && valid_reg[rem_idx];

    assign status.func      = func_reg;
    assign status.out_free  = !m_valid_reg || m_tready;
    assign status.scan_last = (scan_idx_reg == IDX_W'(SLOTS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load_op) begin
            func_reg  <= func_t'(s_tuser[FUNC_W-1:0]);
            index_reg <= s_tdata[SLOT_FIELD_W-1:0];
            time_reg  <= s_tdata[SLOT_FIELD_W +: TIME_W];
            floor_reg <= s_tdata[SLOT_FIELD_W + TIME_W +: FLOOR_W];
        end
    end

    assign mem_we  = cmd.exec_simple && (func_reg == FUNC_ADD) && free_found;
    assign mem_re  = cmd.take_issue || cmd.scan_step;
    assign rd_addr = cmd.take_issue ? take_idx : scan_idx_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_time[free_idx]  <= time_reg;
            mem_floor[free_idx] <= floor_reg;
        end
        if (mem_re) begin
            rd_time_reg  <= mem_time[rd_addr];
            rd_floor_reg <= mem_floor[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            ptr_reg   <= '0;
        end else begin
            if (mem_we) begin
                valid_reg[free_idx] <= 1'b1;
                occ_reg             <= occ_reg + 1'b1;
            end else if (cmd.exec_simple && (func_reg == FUNC_REMOVE) && rem_ok) begin
                valid_reg[rem_idx] <= 1'b0;
                occ_reg            <= occ_reg - 1'b1;
            end else if (cmd.take_issue && take_found) begin
                valid_reg[take_idx] <= 1'b0;
                occ_reg             <= occ_reg - 1'b1;
                ptr_reg             <= ptr_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_issue) begin
            take_ok_reg  <= take_found;
            take_idx_reg <= take_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cmp_reg <= 1'b0;
            best_ok_reg  <= 1'b0;
            scan_idx_reg <= '0;
        end else begin
            scan_cmp_reg <= cmd.scan_step;
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
                best_ok_reg  <= 1'b0;
            end else begin
                if (cmd.scan_step) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                // strict greater keeps the lowest index on ties
                if (scan_cmp_reg && scan_vld_reg
                    && (!best_ok_reg || (rd_time_reg > best_time_reg))) begin
                    best_ok_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            scan_vld_reg  <= valid_reg[scan_idx_reg];
            scan_slot_reg <= scan_idx_reg;
        end
        if (scan_cmp_reg && scan_vld_reg
            && (!best_ok_reg || (rd_time_reg > best_time_reg))) begin
            best_slot_reg  <= scan_slot_reg;
            best_time_reg  <= rd_time_reg;
            best_floor_reg <= rd_floor_reg;
        end
    end

    // result selection
    always_comb begin
        res_ok    = 1'b0;
        res_slot  = '0;
        res_time  = '0;
        res_floor = '0;
        res_occ   = occ_reg;
        if (cmd.exec_simple) begin
            if (func_reg == FUNC_ADD) begin
                res_ok   = free_found;
                res_slot = free_idx;
                res_occ  = free_found ? occ_reg + 1'b1 : occ_reg;
            end else begin
                res_ok   = rem_ok;
                res_slot = rem_idx;
                res_occ  = rem_ok ? occ_reg - 1'b1 : occ_reg;
            end
        end else if (cmd.take_done) begin
            res_ok    = take_ok_reg;
            res_slot  = take_idx_reg;
            res_time  = rd_time_reg;
            res_floor = rd_floor_reg;
        end else begin
            res_ok    = best_ok_reg;
            res_slot  = best_slot_reg;
            res_time  = best_time_reg;
            res_floor = best_floor_reg;
        end
    end

    assign res_load  = cmd.exec_simple || cmd.take_done || cmd.scan_done;
    assign out_slot  = res_ok ? SLOT_FIELD_W'(res_slot) : '0;
    assign out_time  = res_ok ? res_time : '0;
    assign out_floor = res_ok ? res_floor : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= {{PAD_W{1'b0}},
                           (res_occ == '0),
                           (res_occ == CNT_W'(SLOTS)),
                           OCC_FIELD_W'(res_occ),
                           out_floor,
                           out_time,
                           out_slot,
                           res_ok};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// File: hdl/request_slot_buffer_unit.sv
`default_nettype none
// channel  | ports                      | content
// ---------+----------------------------+-----------------------------------------
// request  | s_tvalid s_tready s_tdata  | tuser: func; tdata: slot_index, req_time,
//          | s_tuser                    |   req_floor
// result   | m_tvalid m_tready m_tdata  | ok, slot_out, time_out, floor_out,
//          |                            |   occupied_count, is_full, is_empty
//
// add and remove finish in the execute state, take-next reads one slot of the
// payload memory, and find-newest reads one slot per cycle through all slots.
// one request is worked on at a time; a request is taken while a result waits.
// reset frees every slot and zeroes the round robin pointer.
// a stalled result holds the controller before the next result is written.

module request_slot_buffer_unit #(
    parameter int SLOTS = rsb_pkg::SLOTS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // [2:0] slot_index, [34:3] req_time, [42:35] req_floor
    input  wire  [rsb_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  wire  [rsb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // [0] ok, [3:1] slot_out, [35:4] time_out, [43:36] floor_out,
    // [47:44] occupied_count, [48] is_full, [49] is_empty
    output logic [rsb_pkg::M_TDATA_W-1:0] m_tdata
);
    import rsb_pkg::*;

    rsb_cmd_t    cmd;
    rsb_status_t status;

    rsb_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rsb_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

// File: hdl/rsb_checker.sv
`default_nettype none

module rsb_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire [rsb_pkg::M_TDATA_W-1:0] m_tdata,
    input wire                          m_tvalid,
    input wire                          m_tready
);
    import rsb_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a failed operation reports no slot, time or floor
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[43:1] == '0))
        else $error("failed result carries payload");

    // empty means zero count and never full
    a_empty_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[49] |-> (m_tdata[47:44] == '0) && !m_tdata[48])
        else $error("empty flag inconsistent");

endmodule

bind request_slot_buffer_unit rsb_checker u_rsb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
